[rtl/core/lennard_jones_gradient_2d_macros.svh]
// Assertion macros for the Lennard-Jones gradient block.
// Self-contained; used by the port checker.
`ifndef LENNARD_JONES_GRADIENT_2D_MACROS_SVH
`define LENNARD_JONES_GRADIENT_2D_MACROS_SVH

// Consequent checked in the clock after the antecedent.
`define LJG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define LJG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/ljg_pkg.sv]
// Shared types, constants and helper functions for the Lennard-Jones gradient block.
// No dependencies.
package ljg_pkg;

    localparam int MAX_PARTICLES_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCALE = 2'd1;
    localparam logic [31:0] SIGMA_SQ_RST    = 32'h0100_0000;
    localparam logic [31:0] FORCE_SCALE_RST = 32'h0100_0000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic AXIS_X    = 1'b0;
    localparam logic AXIS_Y    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_COINC = 2'd2;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic               command;
        logic [5:0]         particle_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [31:0]        mass_value;
        logic               component;
        logic [6:0]         particle_count;
    } item_t;

    typedef struct packed {
        logic signed [63:0] gradient;
        logic signed [63:0] acceleration;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat_val_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_I,
        ST_NEXT,
        ST_LOAD_K,
        ST_SQX,
        ST_SQY,
        ST_DIV_U,
        ST_MUL_UU,
        ST_MUL_S6,
        ST_MUL_S12,
        ST_T_CALC,
        ST_DIV_F,
        ST_MUL_TERM,
        ST_ACCUM,
        ST_FIN,
        ST_MUL_G,
        ST_G_ABS,
        ST_DIV_A,
        ST_WB
    } state_t;

    function automatic sat_val_t q32(input logic [127:0] p);
        sat_val_t r;
        r.sat = |p[127:96];
        r.val = r.sat ? '1 : p[95:32];
        return r;
    endfunction

    function automatic sat_val_t to_signed(input logic [63:0] mag, input logic neg);
        sat_val_t r;
        logic [63:0] m;
        r.sat = 1'b0;
        m = mag;
        if (neg) begin
            if (m > SMIN) begin
                r.sat = 1'b1;
                m = SMIN;
            end
            r.val = (~m) + 64'd1;
        end else begin
            if (m > SMAX) begin
                r.sat = 1'b1;
                m = SMAX;
            end
            r.val = m;
        end
        return r;
    endfunction

    function automatic sat_val_t add_sat(input logic [63:0] a, input logic [63:0] b);
        sat_val_t r;
        logic [63:0] s;
        s = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? SMIN : SMAX) : s;
        return r;
    endfunction

endpackage

[rtl/core/ljg_mul.sv]
// Iterative 64x64 unsigned multiplier: four 32x32 partial products, one a cycle.
// Depends on ljg_pkg.
module ljg_mul
    import ljg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic         issue_reg;
    logic         pv_reg;
    logic         done_reg;
    logic [1:0]   step_reg;
    logic [1:0]   pstep_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] prod_shifted;

    assign a_part = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = step_reg[1] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (pstep_reg)
            2'd0:    prod_shifted = {64'd0, prod_reg};
            2'd3:    prod_shifted = {prod_reg, 64'd0};
            default: prod_shifted = {32'd0, prod_reg, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= 2'd0;
            pstep_reg <= 2'd0;
        end
        else if (req.start)
        begin
            issue_reg <= 1'b1;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            pv_reg   <= issue_reg;
            done_reg <= pv_reg && (pstep_reg == 2'd3);
            if (issue_reg)
            begin
                pstep_reg <= step_reg;
                step_reg  <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                    issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else
        begin
            if (issue_reg)
                prod_reg <= a_part * b_part;
            if (pv_reg)
                acc_reg <= acc_reg + prod_shifted;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

[rtl/core/ljg_div.sv]
// Bit-serial 128-by-64 unsigned restoring divider, saturating quotient.
// Depends on ljg_pkg.
module ljg_div
    import ljg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DIV_STEPS = 64;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       lo_reg;
    logic [63:0]       den_reg;
    logic [63:0]       quo_reg;
    logic              sat_reg;
    logic              bad;
    logic [63:0]       shifted;
    logic              take;
    logic [63:0]       rem_step;

    assign bad      = (req.den == 64'd0) || (req.hi >= req.den);
    assign shifted  = {rem_reg[62:0], lo_reg[63]};
    assign take     = rem_reg[63] || (shifted >= den_reg);
    assign rem_step = take ? shifted - den_reg : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= !bad;
            done_reg <= bad;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.hi;
            lo_reg  <= req.lo;
            den_reg <= req.den;
            quo_reg <= bad ? '1 : '0;
            sat_reg <= bad;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            lo_reg  <= {lo_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

endmodule

[rtl/core/lennard_jones_gradient_2d.sv]
// Lennard-Jones gradient block: particle store, sequencer and result register.
// Depends on ljg_pkg, ljg_mul and ljg_div.
//
// A load transaction is written to the store and the block is ready again at once.
// A query runs the particle walk on one iterative multiplier and one
// bit-serial divider, with two divisions per neighbour. A query for a slot
// beyond the store goes straight to write-back. The result register lets
// the next transaction in while a result still waits to be taken.
module lennard_jones_gradient_2d
    import ljg_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    state_t state_reg, state_next;

    logic [31:0] sigma_sq_reg;
    logic [31:0] force_scale_reg;

    logic [31:0] pos_x_mem [MAX_PARTICLES];
    logic [31:0] pos_y_mem [MAX_PARTICLES];
    logic [31:0] mass_mem  [MAX_PARTICLES];
    logic [31:0] rd_x_reg, rd_y_reg, rd_m_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] k_reg;
    logic             axis_reg;

    logic [31:0] xi_reg, yi_reg, mi_reg;
    logic [31:0] ay_reg, dmag_reg;
    logic        dneg_reg;
    logic [63:0] sx_reg, den_reg;
    logic        rc_reg;
    logic [63:0] u_reg, s6_reg, s12_reg;
    logic        tneg_reg;
    logic [63:0] term_reg, acc_reg;
    logic        gneg_reg;
    logic [63:0] gmag_reg;
    logic [63:0] grad_reg, accel_reg;
    logic        sat_reg, coinc_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic        accept;
    logic        in_range;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] count_clamp;
    logic        out_free;
    logic        k_done;
    logic        k_self;

    logic [32:0] dx_w, dy_w;
    logic [31:0] ax_w, ay_w, d_mag_w;
    logic        d_neg_w;
    logic        coinc_k;
    logic [64:0] r2_w;
    logic [63:0] den_w;
    logic [127:0] sig_div;
    logic [63:0] dbl_w, tmag_w;
    logic        tneg_w;
    logic [127:0] t_div;
    logic [63:0] gmag_w, gmag2_w;
    sat_val_t    q_w;
    sat_val_t    term_w;
    sat_val_t    sum_w;
    sat_val_t    grad_w;
    sat_val_t    accel_w;
    logic [63:0] term_mag;
    logic [63:0] grad_mag;

    ljg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ljg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept      = item_valid && item_ready;
    assign in_range    = CMP_W'(item.particle_index) < CMP_W'(MAX_PARTICLES);
    assign cnt_ext     = CMP_W'(item.particle_count);
    assign count_clamp = (cnt_ext > CMP_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                           : CNT_W'(cnt_ext);
    assign out_free    = !result_valid_reg || result_ready;
    assign k_done      = k_reg >= count_reg;
    assign k_self      = k_reg == CNT_W'(idx_reg);

    assign dx_w    = {xi_reg[31], xi_reg} - {rd_x_reg[31], rd_x_reg};
    assign dy_w    = {yi_reg[31], yi_reg} - {rd_y_reg[31], rd_y_reg};
    assign ax_w    = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
    assign ay_w    = dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
    assign d_mag_w = (axis_reg == AXIS_Y) ? ay_w : ax_w;
    assign d_neg_w = (axis_reg == AXIS_Y) ? dy_w[32] : dx_w[32];
    assign coinc_k = (dx_w == 33'd0) && (dy_w == 33'd0);

    assign r2_w    = {1'b0, sx_reg} + {1'b0, mul_rsp.prod[63:0]};
    assign den_w   = r2_w[64] ? r2_w[64:1] : r2_w[63:0];
    assign sig_div = r2_w[64] ? ({96'd0, sigma_sq_reg} << 55) : ({96'd0, sigma_sq_reg} << 56);

    assign dbl_w  = s12_reg[63] ? '1 : {s12_reg[62:0], 1'b0};
    assign tneg_w = s6_reg < dbl_w;
    assign tmag_w = tneg_w ? dbl_w - s6_reg : s6_reg - dbl_w;
    assign t_div  = rc_reg ? ({64'd0, tmag_w} << 47) : ({64'd0, tmag_w} << 48);

    assign gmag_w  = acc_reg[63] ? (~acc_reg) + 64'd1 : acc_reg;
    assign gmag2_w = grad_reg[63] ? (~grad_reg) + 64'd1 : grad_reg;

    assign q_w      = q32(mul_rsp.prod);
    assign term_mag = (|mul_rsp.prod[127:80]) ? '1 : mul_rsp.prod[79:16];
    assign term_w   = to_signed(term_mag, tneg_reg ^ dneg_reg);
    assign sum_w    = add_sat(acc_reg, term_reg);
    assign grad_mag = (|mul_rsp.prod[127:88]) ? '1 : mul_rsp.prod[87:24];
    assign grad_w   = to_signed(grad_mag, gneg_reg);
    assign accel_w  = to_signed(div_rsp.quo, !gneg_reg && (gmag_reg != 64'd0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (item.command == CMD_QUERY))
                    state_next = in_range ? ST_RD_I : ST_WB;
            ST_RD_I:
                state_next = ST_NEXT;
            ST_NEXT:
                if (k_done)
                    state_next = ST_FIN;
                else if (!k_self)
                    state_next = ST_LOAD_K;
            ST_LOAD_K:
                state_next = coinc_k ? ST_NEXT : ST_SQX;
            ST_SQX:
                if (mul_rsp.done)
                    state_next = ST_SQY;
            ST_SQY:
                if (mul_rsp.done)
                    state_next = ST_DIV_U;
            ST_DIV_U:
                if (div_rsp.done)
                    state_next = ST_MUL_UU;
            ST_MUL_UU:
                if (mul_rsp.done)
                    state_next = ST_MUL_S6;
            ST_MUL_S6:
                if (mul_rsp.done)
                    state_next = ST_MUL_S12;
            ST_MUL_S12:
                if (mul_rsp.done)
                    state_next = ST_T_CALC;
            ST_T_CALC:
                state_next = ST_DIV_F;
            ST_DIV_F:
                if (div_rsp.done)
                    state_next = ST_MUL_TERM;
            ST_MUL_TERM:
                if (mul_rsp.done)
                    state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = ST_NEXT;
            ST_FIN:
                state_next = ST_MUL_G;
            ST_MUL_G:
                if (mul_rsp.done)
                    state_next = ST_G_ABS;
            ST_G_ABS:
                state_next = ST_DIV_A;
            ST_DIV_A:
                if (div_rsp.done)
                    state_next = ST_WB;
            ST_WB:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        rd_addr    = k_reg[IDX_W-1:0];
        mul_req    = '0;
        div_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                rd_addr    = IDX_W'(item.particle_index);
            end
            ST_LOAD_K:
            begin
                mul_req.start = !coinc_k;
                mul_req.a     = {32'd0, ax_w};
                mul_req.b     = {32'd0, ax_w};
            end
            ST_SQX:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = {32'd0, ay_reg};
                mul_req.b     = {32'd0, ay_reg};
            end
            ST_SQY:
            begin
                div_req.start = mul_rsp.done;
                div_req.hi    = sig_div[127:64];
                div_req.lo    = sig_div[63:0];
                div_req.den   = den_w;
            end
            ST_DIV_U:
            begin
                mul_req.start = div_rsp.done;
                mul_req.a     = div_rsp.quo;
                mul_req.b     = div_rsp.quo;
            end
            ST_MUL_UU:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = q_w.val;
                mul_req.b     = u_reg;
            end
            ST_MUL_S6:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = q_w.val;
                mul_req.b     = q_w.val;
            end
            ST_T_CALC:
            begin
                div_req.start = 1'b1;
                div_req.hi    = t_div[127:64];
                div_req.lo    = t_div[63:0];
                div_req.den   = den_reg;
            end
            ST_DIV_F:
            begin
                mul_req.start = div_rsp.done;
                mul_req.a     = div_rsp.quo;
                mul_req.b     = {32'd0, dmag_reg};
            end
            ST_FIN:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = gmag_w;
                mul_req.b     = {32'd0, force_scale_reg};
            end
            ST_G_ABS:
            begin
                div_req.start = 1'b1;
                div_req.hi    = {40'd0, gmag2_w[63:40]};
                div_req.lo    = {gmag2_w[39:0], 24'd0};
                div_req.den   = {32'd0, mi_reg};
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sigma_sq_reg     <= SIGMA_SQ_RST;
            force_scale_reg  <= FORCE_SCALE_RST;
            result_valid_reg <= 1'b0;
            k_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == REG_SIGMA_SQ))
                sigma_sq_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_FORCE_SCALE))
                force_scale_reg <= cfg_data;
            if ((state_reg == ST_WB) && out_free)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (state_reg == ST_RD_I)
                k_reg <= '0;
            else if (((state_reg == ST_NEXT) && !k_done && k_self) ||
                     ((state_reg == ST_LOAD_K) && coinc_k) ||
                     (state_reg == ST_ACCUM))
                k_reg <= k_reg + 1'b1;
        end
    end

    // particle store
    always_ff @(posedge clk)
    begin
        if (accept && (item.command == CMD_LOAD) && in_range)
        begin
            pos_x_mem[IDX_W'(item.particle_index)] <= item.coord_x;
            pos_y_mem[IDX_W'(item.particle_index)] <= item.coord_y;
            mass_mem[IDX_W'(item.particle_index)]  <= item.mass_value;
        end
        rd_x_reg <= pos_x_mem[rd_addr];
        rd_y_reg <= pos_y_mem[rd_addr];
        rd_m_reg <= mass_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept && (item.command == CMD_QUERY))
                begin
                    idx_reg   <= IDX_W'(item.particle_index);
                    count_reg <= count_clamp;
                    axis_reg  <= item.component;
                    sat_reg   <= 1'b0;
                    coinc_reg <= 1'b0;
                    grad_reg  <= '0;
                    accel_reg <= '0;
                end
            ST_RD_I:
            begin
                xi_reg  <= rd_x_reg;
                yi_reg  <= rd_y_reg;
                mi_reg  <= rd_m_reg;
                acc_reg <= '0;
            end
            ST_LOAD_K:
            begin
                ay_reg   <= ay_w;
                dmag_reg <= d_mag_w;
                dneg_reg <= d_neg_w;
                if (coinc_k)
                    coinc_reg <= 1'b1;
            end
            ST_SQX:
                if (mul_rsp.done)
                    sx_reg <= mul_rsp.prod[63:0];
            ST_SQY:
                if (mul_rsp.done)
                begin
                    rc_reg  <= r2_w[64];
                    den_reg <= den_w;
                end
            ST_DIV_U:
                if (div_rsp.done)
                begin
                    u_reg   <= div_rsp.quo;
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            ST_MUL_UU:
                if (mul_rsp.done)
                    sat_reg <= sat_reg | q_w.sat;
            ST_MUL_S6:
                if (mul_rsp.done)
                begin
                    s6_reg  <= q_w.val;
                    sat_reg <= sat_reg | q_w.sat;
                end
            ST_MUL_S12:
                if (mul_rsp.done)
                begin
                    s12_reg <= q_w.val;
                    sat_reg <= sat_reg | q_w.sat;
                end
            ST_T_CALC:
            begin
                tneg_reg <= tneg_w;
                sat_reg  <= sat_reg | s12_reg[63];
            end
            ST_DIV_F:
                if (div_rsp.done)
                    sat_reg <= sat_reg | div_rsp.sat;
            ST_MUL_TERM:
                if (mul_rsp.done)
                begin
                    term_reg <= term_w.val;
                    sat_reg  <= sat_reg | term_w.sat;
                end
            ST_ACCUM:
            begin
                acc_reg <= sum_w.val;
                sat_reg <= sat_reg | sum_w.sat;
            end
            ST_FIN:
                gneg_reg <= acc_reg[63];
            ST_MUL_G:
                if (mul_rsp.done)
                begin
                    grad_reg <= grad_w.val;
                    sat_reg  <= sat_reg | grad_w.sat;
                end
            ST_G_ABS:
            begin
                gneg_reg <= grad_reg[63];
                gmag_reg <= gmag2_w;
            end
            ST_DIV_A:
                if (div_rsp.done)
                begin
                    accel_reg <= accel_w.val;
                    sat_reg   <= sat_reg | div_rsp.sat | accel_w.sat;
                end
            ST_WB:
                if (out_free)
                begin
                    result_reg.gradient     <= grad_reg;
                    result_reg.acceleration <= accel_reg;
                    result_reg.status       <= coinc_reg ? STATUS_COINC :
                                               (sat_reg ? STATUS_SAT : STATUS_OK);
                end
            default:
            begin
                tneg_reg <= tneg_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/core/ljg_checker.sv]
// Port-level checker for the Lennard-Jones gradient block, bound to the top level.
// Depends on ljg_pkg and lennard_jones_gradient_2d_macros.svh.
`include "lennard_jones_gradient_2d_macros.svh"

module ljg_checker
    import ljg_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    `LJG_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result dropped or changed while stalled")
    `LJG_ASSERT_NEXT(a_load_no_result, clk, rst_n, item_valid && item_ready && (item.command == CMD_LOAD), !$rose(result_valid), "load transaction produced a result")
    `LJG_ASSERT_NEXT(a_query_busy, clk, rst_n, item_valid && item_ready && (item.command == CMD_QUERY), !item_ready, "ready during a query")
    `LJG_ASSERT_SAME(a_zero_grad_accel, clk, rst_n, result_valid && (result.gradient == 64'sd0) && (result.status == STATUS_OK), result.acceleration == 64'sd0, "zero gradient with nonzero acceleration")

endmodule

bind lennard_jones_gradient_2d ljg_checker u_ljg_checker (.*);
